### rtl/hsfd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the humidity sensor frame decoder.
`default_nettype none

package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int TEMP_SCALE   = 17500;
    localparam int TEMP_OFFSET  = 4500;
    localparam int HUMID_SCALE  = 12500;
    localparam int HUMID_OFFSET = 600;
    localparam int HUMID_MAX    = 10000;

    // Byte slots of the six-byte response
    typedef enum logic [2:0] {
        POS_A_HI  = 3'd0,
        POS_A_LO  = 3'd1,
        POS_A_CRC = 3'd2,
        POS_B_HI  = 3'd3,
        POS_B_LO  = 3'd4,
        POS_B_CRC = 3'd5
    } pos_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FIRST_BAD  = 2'd1,
        STATUS_SECOND_BAD = 2'd2
    } status_t;

    // Completed frame, handed from the framer to the converter and result register
    typedef struct packed {
        logic        done;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
        status_t     status;
    } frame_t;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/hsfd_frame_ctrl.sv
// Byte framer: tracks position, runs the CRC and assembles the two words.
`default_nettype none

module hsfd_frame_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic [7:0]      byte_in,
    input  wire logic            frame_start,
    output hsfd_pkg::frame_t     frame
);
    import hsfd_pkg::*;

    pos_t        pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] first_word_reg, first_word_next;
    logic        first_bad_reg, first_bad_next;
    logic [7:0]  b_hi_reg, b_hi_next;
    logic [7:0]  b_lo_reg, b_lo_next;
    pos_t        cur_pos;

    always_comb
    begin
        // Start flag and unused codes both realign to the first byte
        if (frame_start || (pos_reg > POS_B_CRC)) begin
            cur_pos = POS_A_HI;
        end else begin
            cur_pos = pos_reg;
        end

        pos_next        = pos_reg;
        crc_next        = crc_reg;
        first_word_next = first_word_reg;
        first_bad_next  = first_bad_reg;
        b_hi_next       = b_hi_reg;
        b_lo_next       = b_lo_reg;

        frame.done      = 1'b0;
        frame.temp_raw  = first_word_reg;
        frame.humid_raw = {b_hi_reg, b_lo_reg};
        if (first_bad_reg) begin
            frame.status = STATUS_FIRST_BAD;
        end else if (crc_reg != byte_in) begin
            frame.status = STATUS_SECOND_BAD;
        end else begin
            frame.status = STATUS_OK;
        end

        case (cur_pos)
            POS_A_HI:
            begin
                crc_next        = crc8_step(CRC_INIT, byte_in);
                first_word_next = {byte_in, 8'h00};
                pos_next        = POS_A_LO;
            end
            POS_A_LO:
            begin
                crc_next        = crc8_step(crc_reg, byte_in);
                first_word_next = {first_word_reg[15:8], byte_in};
                pos_next        = POS_A_CRC;
            end
            POS_A_CRC:
            begin
                first_bad_next = (crc_reg != byte_in);
                crc_next       = CRC_INIT;
                pos_next       = POS_B_HI;
            end
            POS_B_HI:
            begin
                crc_next  = crc8_step(CRC_INIT, byte_in);
                b_hi_next = byte_in;
                pos_next  = POS_B_LO;
            end
            POS_B_LO:
            begin
                crc_next  = crc8_step(crc_reg, byte_in);
                b_lo_next = byte_in;
                pos_next  = POS_B_CRC;
            end
            default:
            begin
                frame.done = 1'b1;
                crc_next   = CRC_INIT;
                pos_next   = POS_A_HI;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= POS_A_HI;
            crc_reg        <= CRC_INIT;
            first_word_reg <= '0;
            first_bad_reg  <= 1'b0;
            b_hi_reg       <= '0;
            b_lo_reg       <= '0;
        end else if (advance) begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            first_word_reg <= first_word_next;
            first_bad_reg  <= first_bad_next;
            b_hi_reg       <= b_hi_next;
            b_lo_reg       <= b_lo_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hsfd_convert.sv
// Raw word to hundredths conversion: constant multiply, divide by 65535, offset, and clamp of the humidity.
`default_nettype none

module hsfd_convert (
    input  wire hsfd_pkg::frame_t     frame,
    output logic signed [14:0]        temp_centi,
    output logic        [13:0]        humid_centi
);
    import hsfd_pkg::*;

    logic [30:0]        t_prod;
    logic [30:0]        t_sum;
    logic [14:0]        t_quot;
    logic signed [15:0] t_wide;
    logic [29:0]        h_prod;
    logic [29:0]        h_sum;
    logic [13:0]        h_quot;
    logic [13:0]        h_diff;

    always_comb
    begin
        // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 for quotients below 2^16
        t_prod = {15'd0, frame.temp_raw} * 31'(TEMP_SCALE);
        t_sum  = t_prod + {16'd0, t_prod[30:16]} + 31'd1;
        t_quot = t_sum[30:16];
        t_wide = $signed({1'b0, t_quot}) - 16'(TEMP_OFFSET);
        temp_centi = t_wide[14:0];

        h_prod = {14'd0, frame.humid_raw} * 30'(HUMID_SCALE);
        h_sum  = h_prod + {16'd0, h_prod[29:16]} + 30'd1;
        h_quot = h_sum[29:16];
        h_diff = h_quot - 14'(HUMID_OFFSET);
        if (h_quot < 14'(HUMID_OFFSET)) begin
            humid_centi = '0;
        end else if (h_diff > 14'(HUMID_MAX)) begin
            humid_centi = 14'(HUMID_MAX);
        end else begin
            humid_centi = h_diff;
        end
    end

endmodule

`default_nettype wire

### rtl/humidity_sensor_frame_decoder_top.sv
// Top level of the humidity sensor frame decoder: input register, framer, converter, result register.
`default_nettype none

// Takes the six-byte sensor response one byte per transfer on the slave stream
// (tdata = byte, tuser = start flag that realigns the framer to byte zero) and,
// after the sixth byte, presents one result transfer with both raw words, the
// temperature and humidity in hundredths, and a CRC-8 status (poly 0x31, init
// 0xFF; 0 ok, 1 first word bad, 2 second word bad; first failure wins). Without
// start flags frames run back to back. The block takes one byte per cycle
// while no stall holds it: each byte is registered in the input register,
// the framer, CRC step and constant-multiply conversion run combinationally
// on the held byte, and the result is registered in the output register when
// the framer takes the sixth byte. The only stall is a result still waiting
// in the output register while another sixth byte arrives.
module humidity_sensor_frame_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tuser,   // [0] frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [15:0] temp_raw, [31:16] humid_raw,
                                             // [46:32] temp_centi, [60:47] humid_centi,
                                             // [62:61] frame_status, [63] zero
);
    import hsfd_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_start_reg;
    logic               out_valid_reg;
    logic [62:0]        out_data_reg;
    logic               out_free;
    logic               advance;
    frame_t             frame;
    logic signed [14:0] temp_centi;
    logic [13:0]        humid_centi;

    // Output slot is free when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // Move the held byte on; a sixth byte also needs the output slot
    assign advance       = in_valid_reg && (!frame.done || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    hsfd_frame_ctrl u_frame_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .byte_in     (in_byte_reg),
        .frame_start (in_start_reg),
        .frame       (frame)
    );

    hsfd_convert u_convert (
        .frame       (frame),
        .temp_centi  (temp_centi),
        .humid_centi (humid_centi)
    );

    // Input register: hold the byte until the framer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Result register: load on a completed frame, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && frame.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame.done) begin
            out_data_reg <= {frame.status, humid_centi, temp_centi,
                             frame.humid_raw, frame.temp_raw};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

`ifndef SYNTH
    // Humidity is always clamped to the documented range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[60:47] <= 14'd10000))
        else $error("humid_centi above clamp");

    // Temperature stays within -4500..13000
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata[46:32]) >= -15'sd4500) &&
                           ($signed(m_axis_tdata[46:32]) <= 15'sd13000)))
        else $error("temp_centi out of range");

    // A new result only follows a held byte being consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("result without input byte");

    // An accepted byte is held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted byte lost");
`endif

endmodule

`default_nettype wire
